FILE: hw/rtl/prh_pkg.sv
// Shared types and codes for the packet retransmit history block.
`default_nettype none

package prh_pkg;

	// Request kinds.
	localparam logic KIND_STORE = 1'b0;
	localparam logic KIND_FETCH = 1'b1;

	// Fetch status codes.
	localparam logic [1:0] STATUS_FOUND    = 2'd0;
	localparam logic [1:0] STATUS_MISS     = 2'd1;
	localparam logic [1:0] STATUS_TOO_LONG = 2'd2;

	localparam int SEQ_W     = 16;
	localparam int REQ_LEN_W = 11;
	localparam int DATA_W    = 64;

	// Fetch controller states.
	typedef enum logic [3:0] {
		F_IDLE   = 4'b0001,
		F_META   = 4'b0010,
		F_STATUS = 4'b0100,
		F_STREAM = 4'b1000
	} fetch_state_t;

	// Fetch request handed from the input pipeline to the fetch controller.
	typedef struct packed {
		logic                 start;
		logic [SEQ_W-1:0]     seq;
		logic [REQ_LEN_W-1:0] max_len;
	} fetch_req_t;

endpackage

`default_nettype wire

FILE: hw/rtl/prh_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read.
`default_nettype none

module prh_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire  logic                                    clk,
	input  wire  logic                                    we,
	input  wire  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire  logic [WIDTH-1:0]                        wdata,
	input  wire  logic                                    re,
	input  wire  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic       [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/prh_fetch_ctl.sv
// Fetch controller: slot lookup, status results and packet word streaming.
`default_nettype none

module prh_fetch_ctl import prh_pkg::*; #(
	parameter int SLOT_W = 6,
	parameter int WORD_W = 6,
	parameter int LEN_W  = 10
) (
	input  wire  logic                       clk,
	input  wire  logic                       arst_n,
	input  wire  fetch_req_t                 req,
	input  wire  logic [SLOT_W-1:0]          slot,
	output logic                             busy,
	output logic                             meta_re,
	input  wire  logic                       meta_valid_bit,
	input  wire  logic [SEQ_W-1:0]           meta_tag,
	input  wire  logic [LEN_W-1:0]           meta_len,
	output logic                             data_re,
	output logic [SLOT_W+WORD_W-1:0]         data_raddr,
	input  wire  logic [DATA_W-1:0]          data_rdata,
	output logic                             out_valid,
	input  wire  logic                       out_ready,
	output logic [1:0]                       status,
	output logic [DATA_W-1:0]                out_word,
	output logic [3:0]                       byte_count,
	output logic [9:0]                       stored_len,
	output logic                             final_res
);

	localparam int CW = ((LEN_W > WORD_W + 3) ? LEN_W : WORD_W + 3) + 1;
	localparam int MW = (LEN_W > REQ_LEN_W) ? LEN_W : REQ_LEN_W;

	fetch_state_t          state_q;
	logic [SLOT_W-1:0]     slot_q;
	logic [SEQ_W-1:0]      seq_q;
	logic [REQ_LEN_W-1:0]  max_q;
	logic [LEN_W-1:0]      len_q;
	logic [1:0]            st_code_q;
	logic [9:0]            st_len_q;
	logic [WORD_W-1:0]     iss_idx_q;
	logic                  issuing_q;
	logic                  pend_q;
	logic [WORD_W-1:0]     pend_idx_q;

	logic                  out_valid_q;
	logic [1:0]            status_q;
	logic [DATA_W-1:0]     out_word_q;
	logic [3:0]            byte_count_q;
	logic [9:0]            stored_len_q;
	logic                  final_q;

	logic                  hit;
	logic                  too_long;
	logic                  out_free;
	logic                  out_load;
	logic                  st_load;
	logic                  issue;
	logic [CW-1:0]         iss_rem;
	logic                  iss_last;
	logic [CW-1:0]         pend_rem;
	logic                  pend_final;
	logic [3:0]            pend_cnt;
	logic [DATA_W-1:0]     pend_mask;

	assign busy    = (state_q != F_IDLE);
	assign meta_re = req.start;

	assign hit      = meta_valid_bit && (meta_tag == seq_q);
	assign too_long = MW'(meta_len) > MW'(max_q);

	assign out_free = !out_valid_q || out_ready;
	assign out_load = (state_q == F_STREAM) && pend_q && out_free;
	assign st_load  = (state_q == F_STATUS) && out_free;

	// Words stream one per cycle while the output is not stalled: the RAM read
	// register acts as a second buffer behind the output register.
	assign iss_rem  = CW'(len_q) - CW'({iss_idx_q, 3'b000});
	assign iss_last = (iss_rem <= CW'(8));
	assign issue    = (state_q == F_STREAM) && issuing_q && (!pend_q || out_load);

	assign data_re    = issue;
	assign data_raddr = {slot_q, iss_idx_q};

	assign pend_rem   = CW'(len_q) - CW'({pend_idx_q, 3'b000});
	assign pend_final = (pend_rem <= CW'(8));
	assign pend_cnt   = pend_final ? pend_rem[3:0] : 4'd8;
	assign pend_mask  = (pend_cnt == 4'd8) ? {DATA_W{1'b1}}
	                  : ((64'd1 << {pend_cnt, 3'b000}) - 64'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= F_IDLE;
			issuing_q <= 1'b0;
			pend_q    <= 1'b0;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (req.start) begin
						state_q <= F_META;
					end
				end
				F_META: begin
					if (!hit || too_long || (meta_len == '0)) begin
						state_q <= F_STATUS;
					end else begin
						state_q   <= F_STREAM;
						issuing_q <= 1'b1;
					end
				end
				F_STATUS: begin
					if (out_free) begin
						state_q <= F_IDLE;
					end
				end
				F_STREAM: begin
					if (issue && iss_last) begin
						issuing_q <= 1'b0;
					end
					if (issue) begin
						pend_q <= 1'b1;
					end else if (out_load) begin
						pend_q <= 1'b0;
					end
					if (out_load && pend_final) begin
						state_q <= F_IDLE;
					end
				end
				default: begin
					state_q <= F_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			slot_q <= slot;
			seq_q  <= req.seq;
			max_q  <= req.max_len;
		end
		if (state_q == F_META) begin
			len_q     <= meta_len;
			iss_idx_q <= '0;
			if (!hit) begin
				st_code_q <= STATUS_MISS;
				st_len_q  <= '0;
			end else if (too_long) begin
				st_code_q <= STATUS_TOO_LONG;
				st_len_q  <= 10'(meta_len);
			end else begin
				st_code_q <= STATUS_FOUND;
				st_len_q  <= '0;
			end
		end
		if (issue) begin
			iss_idx_q  <= iss_idx_q + 1'b1;
			pend_idx_q <= iss_idx_q;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load || st_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			status_q     <= STATUS_FOUND;
			out_word_q   <= data_rdata & pend_mask;
			byte_count_q <= pend_cnt;
			stored_len_q <= 10'(len_q);
			final_q      <= pend_final;
		end else if (st_load) begin
			status_q     <= st_code_q;
			out_word_q   <= '0;
			byte_count_q <= 4'd0;
			stored_len_q <= st_len_q;
			final_q      <= 1'b1;
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign out_word   = out_word_q;
	assign byte_count = byte_count_q;
	assign stored_len = stored_len_q;
	assign final_res  = final_q;

`ifndef SYNTHESIS
	a_read_only_streaming: assert property (@(posedge clk) disable iff (!arst_n)
		data_re |-> (state_q == F_STREAM))
		else $error("packet word read outside streaming");

	a_no_pending_in_status: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == F_STATUS) |-> !pend_q)
		else $error("pending packet word during status result");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (byte_count_q <= 4'd8))
		else $error("byte count above eight");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/packet_retransmit_history.sv
// Top level of the direct-mapped packet retransmit history.
// A request passes stage 1 and stage 2; a store word is written from stage 2. A fetch
// reads the slot table, then gives a status result or its packet words, one word per
// cycle while the output is not stalled. Store requests are taken one per cycle while
// no fetch is in progress; a fetch holds the input until its final result is loaded.
// Reset: asynchronous, active low; afterwards the slot table is swept clear, and no
// request is taken during the sweep.
`default_nettype none

module packet_retransmit_history import prh_pkg::*; #(
	parameter int SLOTS            = 64,
	parameter int MAX_PACKET_BYTES = 512
) (
	input  wire  logic                 clk,
	input  wire  logic                 arst_n,
	input  wire  logic                 in_valid,
	output logic                       in_ready,
	input  wire  logic                 kind,
	input  wire  logic [SEQ_W-1:0]     seq,
	input  wire  logic [REQ_LEN_W-1:0] packet_len,
	input  wire  logic [DATA_W-1:0]    data_word,
	input  wire  logic                 last,
	input  wire  logic [REQ_LEN_W-1:0] max_len,
	output logic                       out_valid,
	input  wire  logic                 out_ready,
	output logic [1:0]                 status,
	output logic [DATA_W-1:0]          out_word,
	output logic [3:0]                 byte_count,
	output logic [9:0]                 stored_len,
	output logic                       final_res
);

	// Packet words per slot, and the slot table layout.
	localparam int WORDS      = (MAX_PACKET_BYTES + 7) / 8;
	localparam int WORD_W     = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int SLOT_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int LEN_W      = $clog2(MAX_PACKET_BYTES + 1);
	localparam int META_W     = 1 + SEQ_W + LEN_W;
	localparam int DATA_DEPTH = SLOTS * (2 ** WORD_W);
	localparam int PROD2_W    = SEQ_W + 12;

	// The slot is seq modulo SLOTS. The quotient estimate from the reciprocal
	// is never more than one too small, so one conditional subtract finishes it.
	localparam logic [32:0] RECIP = 33'((64'd1 << 32) / SLOTS);

	// Stage 1: the accepted request and its quotient estimate.
	logic                   v_s1;
	logic                   kind_s1;
	logic [SEQ_W-1:0]       seq_s1;
	logic [REQ_LEN_W-1:0]   plen_s1;
	logic [DATA_W-1:0]      word_s1;
	logic                   last_s1;
	logic [REQ_LEN_W-1:0]   max_s1;
	logic [SEQ_W-1:0]       quot_s1;

	// Stage 2: the request with its slot, handled when the fetch side is idle.
	logic                   v_s2;
	logic                   kind_s2;
	logic [SEQ_W-1:0]       seq_s2;
	logic [REQ_LEN_W-1:0]   plen_s2;
	logic [DATA_W-1:0]      word_s2;
	logic                   last_s2;
	logic [REQ_LEN_W-1:0]   max_s2;
	logic [SLOT_W-1:0]      slot_s2;

	logic [WORD_W-1:0]      ptr_q;
	logic                   clr_q;
	logic [SLOT_W-1:0]      clr_idx_q;

	logic [48:0]            prod1;
	logic [PROD2_W-1:0]     prod2;
	logic [PROD2_W-1:0]     rem1;
	logic [PROD2_W-1:0]     rem2;

	logic                   fetch_busy;
	logic                   adv;
	logic                   proc_s2;
	logic                   store_s2;
	logic                   oversized_s2;
	fetch_req_t             fetch_req;

	logic                   meta_we;
	logic [SLOT_W-1:0]      meta_waddr;
	logic [META_W-1:0]      meta_wdata;
	logic                   meta_re;
	logic [META_W-1:0]      meta_rdata;

	logic                   data_we;
	logic                   data_re;
	logic [SLOT_W+WORD_W-1:0] data_raddr;
	logic [DATA_W-1:0]      data_rdata;

	// The pipeline moves only while no fetch is in progress and the sweep is done.
	assign adv      = !fetch_busy && !clr_q;
	assign in_ready = adv;

	assign prod1 = 49'(seq) * 49'(RECIP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	assign prod2 = PROD2_W'(quot_s1) * PROD2_W'(SLOTS);
	assign rem1  = PROD2_W'(seq_s1) - prod2;
	assign rem2  = (rem1 >= PROD2_W'(SLOTS)) ? (rem1 - PROD2_W'(SLOTS)) : rem1;

	always_ff @(posedge clk) begin
		if (adv) begin
			kind_s1 <= kind;
			seq_s1  <= seq;
			plen_s1 <= packet_len;
			word_s1 <= data_word;
			last_s1 <= last;
			max_s1  <= max_len;
			quot_s1 <= prod1[47:32];

			kind_s2 <= kind_s1;
			seq_s2  <= seq_s1;
			plen_s2 <= plen_s1;
			word_s2 <= word_s1;
			last_s2 <= last_s1;
			max_s2  <= max_s1;
			slot_s2 <= SLOT_W'(rem2);
		end
	end

	// A stage 2 request is handled in the cycle the pipeline advances.
	assign proc_s2      = v_s2 && adv;
	assign store_s2     = proc_s2 && (kind_s2 == KIND_STORE);
	assign oversized_s2 = 12'(plen_s2) > 12'(MAX_PACKET_BYTES);

	// Word pointer of the packet being streamed in. It wraps after the
	// last word position and returns to zero on every final word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0;
		end else if (store_s2) begin
			if (last_s2) begin
				ptr_q <= '0;
			end else if (!oversized_s2) begin
				if (ptr_q == WORD_W'(WORDS - 1)) begin
					ptr_q <= '0;
				end else begin
					ptr_q <= ptr_q + 1'b1;
				end
			end
		end
	end

	// Sweep that clears every slot's valid mark after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= 1'b1;
			clr_idx_q <= '0;
		end else if (clr_q) begin
			clr_idx_q <= clr_idx_q + 1'b1;
			if (clr_idx_q == SLOT_W'(SLOTS - 1)) begin
				clr_q <= 1'b0;
			end
		end
	end

	// Slot table writes. The first word of a packet drops the valid mark so a
	// fetch during streaming misses; the final word sets tag, length and valid.
	// No read is needed, as each write supplies the whole entry.
	always_comb begin
		meta_we    = 1'b0;
		meta_waddr = slot_s2;
		meta_wdata = {1'b0, seq_s2, LEN_W'(plen_s2)};
		if (clr_q) begin
			meta_we    = 1'b1;
			meta_waddr = clr_idx_q;
			meta_wdata = '0;
		end else if (store_s2 && !oversized_s2) begin
			if (last_s2) begin
				meta_we    = 1'b1;
				meta_wdata = {1'b1, seq_s2, LEN_W'(plen_s2)};
			end else if (ptr_q == '0) begin
				meta_we = 1'b1;
			end
		end
	end

	assign data_we = store_s2 && !oversized_s2;

	assign fetch_req.start   = proc_s2 && (kind_s2 == KIND_FETCH);
	assign fetch_req.seq     = seq_s2;
	assign fetch_req.max_len = max_s2;

	prh_ram #(
		.WIDTH (META_W),
		.DEPTH (SLOTS)
	) u_meta_ram (
		.clk   (clk),
		.we    (meta_we),
		.waddr (meta_waddr),
		.wdata (meta_wdata),
		.re    (meta_re),
		.raddr (slot_s2),
		.rdata (meta_rdata)
	);

	prh_ram #(
		.WIDTH (DATA_W),
		.DEPTH (DATA_DEPTH)
	) u_data_ram (
		.clk   (clk),
		.we    (data_we),
		.waddr ({slot_s2, ptr_q}),
		.wdata (word_s2),
		.re    (data_re),
		.raddr (data_raddr),
		.rdata (data_rdata)
	);

	prh_fetch_ctl #(
		.SLOT_W (SLOT_W),
		.WORD_W (WORD_W),
		.LEN_W  (LEN_W)
	) u_fetch_ctl (
		.clk            (clk),
		.arst_n         (arst_n),
		.req            (fetch_req),
		.slot           (slot_s2),
		.busy           (fetch_busy),
		.meta_re        (meta_re),
		.meta_valid_bit (meta_rdata[META_W-1]),
		.meta_tag       (meta_rdata[META_W-2:LEN_W]),
		.meta_len       (meta_rdata[LEN_W-1:0]),
		.data_re        (data_re),
		.data_raddr     (data_raddr),
		.data_rdata     (data_rdata),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status         (status),
		.out_word       (out_word),
		.byte_count     (byte_count),
		.stored_len     (stored_len),
		.final_res      (final_res)
	);

`ifndef SYNTHESIS
	a_no_store_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		clr_q |-> (!data_we && !in_ready))
		else $error("request taken during slot sweep");

	a_no_store_in_fetch: assert property (@(posedge clk) disable iff (!arst_n)
		fetch_busy |-> (!data_we && !fetch_req.start))
		else $error("store or new fetch while a fetch is in progress");

	a_fetch_starts: assert property (@(posedge clk) disable iff (!arst_n)
		fetch_req.start |=> fetch_busy)
		else $error("fetch request not taken by the controller");
`endif

endmodule

`default_nettype wire
